>>> sv/npcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette color match block.
// ----------------------------------------------------------------------------
package npcm_pkg;

  // palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int CHAN_W          = 8;
  localparam int ENTRY_W         = 8;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int DIST_W          = 20;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_RESULT
  } npcm_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             wr_en;
    logic             load_query;
    logic             rd_en;
    logic             rd_first;
    logic             rd_last;
    logic [IDX_W-1:0] rd_addr;
  } npcm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
  } npcm_stat_t;

endpackage
`default_nettype wire

>>> sv/npcm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_ctrl
// Controller: takes items, sequences the palette scan and strobes the result.
// ----------------------------------------------------------------------------
module npcm_ctrl
  import npcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       in_func,
  output logic            busy,
  output logic            out_valid,
  output npcm_cmd_t       cmd,
  input  wire npcm_stat_t stat
);

  npcm_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             accept;

  assign accept = start && (state_r == ST_IDLE);

  // state and scan address registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_QUERY)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (addr_r == LAST_IDX) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.scan_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // scan address counter
  always_comb begin
    addr_nxt = addr_r;
    case (state_r)
      ST_IDLE: addr_nxt = '0;
      ST_SCAN: begin
        if (addr_r != LAST_IDX) addr_nxt = addr_r + 1'b1;
      end
      default: addr_nxt = addr_r;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    busy           = (state_r != ST_IDLE);
    out_valid      = (state_r == ST_RESULT);
    cmd.wr_en      = accept && (in_func == FUNC_WRITE);
    cmd.load_query = accept && (in_func == FUNC_QUERY);
    cmd.rd_en      = (state_r == ST_SCAN);
    cmd.rd_first   = (addr_r == '0);
    cmd.rd_last    = (addr_r == LAST_IDX);
    cmd.rd_addr    = addr_r;
  end

endmodule
`default_nettype wire

>>> sv/npcm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_dp
// Datapath: palette memory, weighted distance pipeline and best tracker.
// ----------------------------------------------------------------------------
module npcm_dp
  import npcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire npcm_cmd_t          cmd,
  input  wire logic [ENTRY_W-1:0] in_entry_index,
  input  wire logic [CHAN_W-1:0]  in_red,
  input  wire logic [CHAN_W-1:0]  in_green,
  input  wire logic [CHAN_W-1:0]  in_blue,
  output logic [ENTRY_W-1:0]      out_best_index,
  output npcm_stat_t              stat
);

  logic [3*CHAN_W-1:0] mem [PALETTE_ENTRIES];

  // query color
  logic [CHAN_W-1:0] qr_r, qg_r, qb_r;

  // stage 1: memory read
  logic [3*CHAN_W-1:0] rd_data_r;
  logic                v1_r, first1_r, last1_r;
  logic [IDX_W-1:0]    idx1_r;

  // stage 2: squared channel differences
  logic [SQ_W-1:0]  sqr_r, sqg_r, sqb_r;
  logic             v2_r, first2_r, last2_r;
  logic [IDX_W-1:0] idx2_r;

  // stage 3: weighted distance
  logic [DIST_W-1:0] dist_r;
  logic              v3_r, first3_r, last3_r;
  logic [IDX_W-1:0]  idx3_r;

  // best so far
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;

  logic              wr_ok;
  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sqr_nxt, sqg_nxt, sqb_nxt;
  logic [DIST_W-1:0] dist_nxt;

  // writes beyond the palette are dropped
  assign wr_ok = cmd.wr_en &&
                 ({1'b0, in_entry_index} < (ENTRY_W + 1)'(PALETTE_ENTRIES));

  // palette memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_ok) mem[in_entry_index[IDX_W-1:0]] <= {in_red, in_green, in_blue};
    if (cmd.rd_en) rd_data_r <= mem[cmd.rd_addr];
  end

  // query color capture
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qr_r <= in_red;
      qg_r <= in_green;
      qb_r <= in_blue;
    end
  end

  // absolute differences and squares
  always_comb begin
    dr = (qr_r >= rd_data_r[3*CHAN_W-1:2*CHAN_W]) ?
         qr_r - rd_data_r[3*CHAN_W-1:2*CHAN_W] : rd_data_r[3*CHAN_W-1:2*CHAN_W] - qr_r;
    dg = (qg_r >= rd_data_r[2*CHAN_W-1:CHAN_W]) ?
         qg_r - rd_data_r[2*CHAN_W-1:CHAN_W] : rd_data_r[2*CHAN_W-1:CHAN_W] - qg_r;
    db = (qb_r >= rd_data_r[CHAN_W-1:0]) ?
         qb_r - rd_data_r[CHAN_W-1:0] : rd_data_r[CHAN_W-1:0] - qb_r;
    sqr_nxt = SQ_W'(dr) * SQ_W'(dr);
    sqg_nxt = SQ_W'(dg) * SQ_W'(dg);
    sqb_nxt = SQ_W'(db) * SQ_W'(db);
  end

  // weights 3, 6 and 1 as shifts and adds
  always_comb begin
    dist_nxt = DIST_W'(sqr_r) + (DIST_W'(sqr_r) << 1)
             + (DIST_W'(sqg_r) << 2) + (DIST_W'(sqg_r) << 1)
             + DIST_W'(sqb_r);
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    idx1_r   <= cmd.rd_addr;
    first1_r <= cmd.rd_first;
    last1_r  <= cmd.rd_last;
    sqr_r    <= sqr_nxt;
    sqg_r    <= sqg_nxt;
    sqb_r    <= sqb_nxt;
    idx2_r   <= idx1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    dist_r   <= dist_nxt;
    idx3_r   <= idx2_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // keep the first strictly smaller distance
  always_ff @(posedge clk) begin
    if (v3_r && (first3_r || (dist_r < best_dist_r))) begin
      best_dist_r <= dist_r;
      best_idx_r  <= idx3_r;
    end
  end

  assign stat.scan_done = v3_r && last3_r;
  assign out_best_index = ENTRY_W'(best_idx_r);

endmodule
`default_nettype wire

>>> sv/nearest_palette_color_match_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_match_top
// Weighted nearest palette color search over a 256-entry RGB palette.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on a rising edge with start high and busy low.
//   in_func = write stores {in_red, in_green, in_blue} at in_entry_index;
//   it gives no result and busy stays low.
//   in_func = query scans the palette for the entry with the least
//   3*dr^2 + 6*dg^2 + db^2 and reports its index, lowest index on ties.
//   The result shows on out_best_index for one cycle with out_valid high.
//   Busy is high from the accepting edge until the out_valid cycle ends,
//   so no new word is taken before a query is through. The scan reads
//   one entry per cycle from the palette memory into a three-stage pipe
//   of memory read, squared channel differences and weighted distance.
//   Every palette entry must be written before the first query.
//   Reset clears the controller and the pipeline valid bits only; palette contents are kept.
//   The receiver has no stall: out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_top
  import npcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_func,
  input  wire logic [ENTRY_W-1:0] in_entry_index,
  input  wire logic [CHAN_W-1:0]  in_red,
  input  wire logic [CHAN_W-1:0]  in_green,
  input  wire logic [CHAN_W-1:0]  in_blue,
  output logic                    out_valid,
  output logic [ENTRY_W-1:0]      out_best_index
);

  npcm_cmd_t  cmd;
  npcm_stat_t stat;

  // controller
  npcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath
  npcm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_best_index (out_best_index),
    .stat           (stat)
  );

endmodule
`default_nettype wire
